@@ hw/rtl/hla_pkg.sv @@
// Shared types, sizes and trig tables for the Hough line accumulator.
// Depends on nothing; every other file but hla_ram imports it.
package hla_pkg;

	// Accumulator geometry
	localparam int ANGLE_BINS  = 180;
	localparam int RHO_BINS    = 2048;
	localparam int IMAGE_DIM   = 512;
	localparam int COUNT_WIDTH = 16;

	// Request field widths
	localparam int OP_W      = 2;
	localparam int PIX_W     = 10;
	localparam int VAL_W     = 8;
	localparam int ANG_FLD_W = 8;
	localparam int RHO_FLD_W = 11;

	// Vote store addressing
	localparam int STORE_DEPTH = ANGLE_BINS * RHO_BINS;
	localparam int ADDR_W      = $clog2(STORE_DEPTH);
	localparam int ANG_W       = $clog2(ANGLE_BINS);
	localparam int BIN_W       = $clog2(RHO_BINS);

	// Fixed-point datapath: Q1.16 trig, exact products, rounded rho
	localparam int ROM_W  = 18;
	localparam int FRAC_W = 16;
	localparam int PROD_W = PIX_W + 1 + ROM_W;
	localparam int SUM_W  = PROD_W + 1;
	localparam int MAG_W  = SUM_W - FRAC_W;
	localparam int BSUM_W = ((MAG_W > BIN_W) ? MAG_W : BIN_W) + 2;

	// Command queue between front and back
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

	typedef enum logic [OP_W-1:0] {
		OP_ACCUM = 2'd0,
		OP_CLEAR = 2'd1,
		OP_READ  = 2'd2
	} op_t;

	typedef enum logic [1:0] {
		CMD_ACCUM,
		CMD_CLEAR,
		CMD_READ
	} cmd_kind_t;

	typedef struct packed {
		cmd_kind_t          kind;
		logic [PIX_W-1:0]   pix_x;
		logic [PIX_W-1:0]   pix_y;
		logic               rd_hit;
		logic [ADDR_W-1:0]  rd_addr;
	} cmd_t;

	typedef struct packed {
		logic valid;
		cmd_t cmd;
	} head_t;

	typedef struct packed {
		logic take;
		logic init;
	} back_stat_t;

	typedef struct packed {
		logic                   push;
		logic [COUNT_WIDTH-1:0] count;
	} res_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_SWEEP,
		ST_DRAIN,
		ST_READ,
		ST_RESULT
	} state_t;

	// Table generation: integer Taylor series in Q30, folded about pi/2
	localparam longint unsigned PI_Q30       = 64'd3373259426;
	localparam longint unsigned ONE_Q30      = 64'd1 << 30;
	localparam longint unsigned ANGLE_BINS_L = 64'(ANGLE_BINS);
	localparam longint unsigned HALF_BINS_L  = 64'(ANGLE_BINS / 2);
	localparam int              SERIES_TERMS = 14;
	localparam longint unsigned SIN_DIV [SERIES_TERMS] = '{
		64'd6, 64'd20, 64'd42, 64'd72, 64'd110, 64'd156, 64'd210,
		64'd272, 64'd342, 64'd420, 64'd506, 64'd600, 64'd702, 64'd812
	};
	localparam longint unsigned COS_DIV [SERIES_TERMS] = '{
		64'd2, 64'd12, 64'd30, 64'd56, 64'd90, 64'd132, 64'd182,
		64'd240, 64'd306, 64'd380, 64'd462, 64'd552, 64'd650, 64'd756
	};

	function automatic longint q30_to_q16(input longint v);
		longint r;
		if (v >= 0) begin
			r = (v + 64'sd8192) >>> 14;
		end else begin
			r = -((-v + 64'sd8192) >>> 14);
		end
		return r;
	endfunction

	function automatic logic [ANGLE_BINS*ROM_W-1:0] build_trig_table(input logic want_sin);
		logic [ANGLE_BINS*ROM_W-1:0] tbl;
		longint unsigned u;
		longint unsigned x;
		longint unsigned x2;
		longint unsigned ts;
		longint unsigned tc;
		longint ss;
		longint cc;
		longint val;
		logic flip;
		tbl = '0;
		for (int t = 0; t < ANGLE_BINS; t++) begin
			flip = (2 * t) > ANGLE_BINS;
			u    = flip ? 64'(ANGLE_BINS - t) : 64'(t);
			x    = (PI_Q30 * u + HALF_BINS_L) / ANGLE_BINS_L;
			x2   = (x * x) >> 30;
			ts   = x;
			tc   = ONE_Q30;
			ss   = longint'(x);
			cc   = longint'(ONE_Q30);
			for (int k = 0; k < SERIES_TERMS; k++) begin
				ts = ((ts * x2) >> 30) / SIN_DIV[k];
				tc = ((tc * x2) >> 30) / COS_DIV[k];
				// terms with even k subtract, terms with odd k add
				if ((k % 2) == 0) begin
					ss = ss - longint'(ts);
					cc = cc - longint'(tc);
				end else begin
					ss = ss + longint'(ts);
					cc = cc + longint'(tc);
				end
			end
			if (want_sin) begin
				val = q30_to_q16(ss);
			end else begin
				val = flip ? -q30_to_q16(cc) : q30_to_q16(cc);
			end
			tbl[t*ROM_W +: ROM_W] = ROM_W'(val);
		end
		return tbl;
	endfunction

	localparam logic [ANGLE_BINS*ROM_W-1:0] COS_TABLE = build_trig_table(1'b0);
	localparam logic [ANGLE_BINS*ROM_W-1:0] SIN_TABLE = build_trig_table(1'b1);

endpackage

@@ hw/rtl/hla_ram.sv @@
// Generic simple dual-port RAM: one write port, one read port, registered read.
// Depends on nothing.
module hla_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// Write one word, register one read
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

@@ hw/rtl/hla_front.sv @@
// Front end: accepts requests, classifies them, drops those with no effect,
// and queues the rest for the back end. Depends on hla_pkg.
module hla_front (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          push,
	output logic                          full,
	input  logic [hla_pkg::OP_W-1:0]      operation,
	input  logic [hla_pkg::PIX_W-1:0]     pixel_x,
	input  logic [hla_pkg::PIX_W-1:0]     pixel_y,
	input  logic [hla_pkg::VAL_W-1:0]     pixel_value,
	input  logic [hla_pkg::ANG_FLD_W-1:0] angle_bin,
	input  logic [hla_pkg::RHO_FLD_W-1:0] rho_bin,
	output hla_pkg::head_t                head,
	input  hla_pkg::back_stat_t           stat
);
	import hla_pkg::*;

	cmd_t              queue_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QPTR_W:0]   count_q;
	cmd_t              cmd_in;
	logic              keep;
	logic              pix_ok;
	logic              rd_hit;
	logic              enq;
	logic              deq;

	// Classify the incoming request
	assign pix_ok = (pixel_value != '0)
		&& (pixel_x != '0) && (32'(pixel_x) <= IMAGE_DIM)
		&& (pixel_y != '0) && (32'(pixel_y) <= IMAGE_DIM);
	assign rd_hit = (32'(angle_bin) < ANGLE_BINS) && (32'(rho_bin) < RHO_BINS);

	always_comb begin
		cmd_in         = '0;
		keep           = 1'b0;
		cmd_in.pix_x   = pixel_x;
		cmd_in.pix_y   = pixel_y;
		cmd_in.rd_hit  = rd_hit;
		cmd_in.rd_addr = ADDR_W'(ADDR_W'(angle_bin) * ADDR_W'(RHO_BINS) + ADDR_W'(rho_bin));
		unique case (operation)
			OP_ACCUM: begin
				cmd_in.kind = CMD_ACCUM;
				keep        = pix_ok;
			end
			OP_CLEAR: begin
				cmd_in.kind = CMD_CLEAR;
				keep        = 1'b1;
			end
			OP_READ: begin
				cmd_in.kind = CMD_READ;
				keep        = 1'b1;
			end
			default: begin
				cmd_in.kind = CMD_ACCUM;
				keep        = 1'b0;
			end
		endcase
	end

	// Hold off requests while the queue is full or the store is being initialized
	assign full = (count_q == (QPTR_W+1)'(QUEUE_DEPTH)) || stat.init;
	assign enq  = push && !full && keep;
	assign deq  = stat.take;

	// Advance pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (enq) begin
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QUEUE_DEPTH-1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (deq) begin
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QUEUE_DEPTH-1)) ? '0 : rd_ptr_q + 1'b1;
			end
			unique case ({enq, deq})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	// Store queued commands
	always_ff @(posedge clk) begin
		if (enq) begin
			queue_q[wr_ptr_q] <= cmd_in;
		end
	end

	assign head.valid = (count_q != '0);
	assign head.cmd   = queue_q[rd_ptr_q];

endmodule

@@ hw/rtl/hla_back.sv @@
// Back end: runs queued commands against the vote store: angle sweep with a
// read-modify-write pipeline, clearing pass, and single-bin read. Depends on hla_pkg.
module hla_back (
	input  logic                            clk,
	input  logic                            arst_n,
	input  hla_pkg::head_t                  head,
	output hla_pkg::back_stat_t             stat,
	input  logic                            out_full,
	output hla_pkg::res_t                   res,
	output logic                            ram_we,
	output logic [hla_pkg::ADDR_W-1:0]      ram_waddr,
	output logic [hla_pkg::COUNT_WIDTH-1:0] ram_wdata,
	output logic                            ram_re,
	output logic [hla_pkg::ADDR_W-1:0]      ram_raddr,
	input  logic [hla_pkg::COUNT_WIDTH-1:0] ram_rdata
);
	import hla_pkg::*;

	state_t            state_q;
	state_t            state_d;
	logic              init_q;
	logic [ADDR_W-1:0] clr_addr_q;
	logic [ANG_W-1:0]  t_q;
	logic [PIX_W-1:0]  x_q;
	logic [PIX_W-1:0]  y_q;
	logic              rd_hit_q;
	logic [ADDR_W-1:0] rd_addr_q;

	// Sweep pipeline
	logic                     v_s1, v_s2, v_s3, v_s4, v_s5, upd_s6;
	logic [ANG_W-1:0]         t_s1, t_s2, t_s3, t_s4, t_s5;
	logic signed [ROM_W-1:0]  cos_s1, sin_s1;
	logic signed [PROD_W-1:0] px_s2, py_s2;
	logic signed [SUM_W-1:0]  sum_s3;
	logic                     neg_s4;
	logic [MAG_W-1:0]         rmag_s4;
	logic                     ok_s5;
	logic [BIN_W-1:0]         bin_s5;
	logic [ADDR_W-1:0]        addr_s6;

	logic                     take;
	logic                     issue;
	logic                     clr_last;
	logic                     t_last;
	logic                     pipe_busy;
	logic signed [PIX_W:0]    xs;
	logic signed [PIX_W:0]    ys;
	logic [SUM_W-1:0]         mag;
	logic [SUM_W-1:0]         rnd;
	logic signed [BSUM_W-1:0] bin_full;
	logic signed [BSUM_W-1:0] mag_ext;
	logic signed [BSUM_W-1:0] rho_off;
	logic signed [BSUM_W-1:0] rho_lim;
	logic [ADDR_W-1:0]        sweep_addr;

	assign clr_last  = (clr_addr_q == ADDR_W'(STORE_DEPTH-1));
	assign t_last    = (t_q == ANG_W'(ANGLE_BINS-1));
	assign pipe_busy = v_s1 || v_s2 || v_s3 || v_s4 || v_s5 || upd_s6;

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_CLEAR: begin
				if (clr_last) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (take) begin
					unique case (head.cmd.kind)
						CMD_ACCUM: state_d = ST_SWEEP;
						CMD_CLEAR: state_d = ST_CLEAR;
						CMD_READ:  state_d = ST_READ;
						default:   state_d = ST_IDLE;
					endcase
				end
			end
			ST_SWEEP: begin
				if (t_last) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				if (!pipe_busy) begin
					state_d = ST_IDLE;
				end
			end
			ST_READ:   state_d = ST_RESULT;
			ST_RESULT: state_d = ST_IDLE;
			default:   state_d = ST_IDLE;
		endcase
	end

	// Outputs: command pop, sweep issue, store ports, result
	assign sweep_addr = ADDR_W'(ADDR_W'(t_s5) * ADDR_W'(RHO_BINS) + ADDR_W'(bin_s5));

	always_comb begin
		take      = 1'b0;
		issue     = 1'b0;
		ram_re    = ok_s5;
		ram_raddr = sweep_addr;
		ram_we    = upd_s6;
		ram_waddr = addr_s6;
		ram_wdata = ram_rdata + 1'b1;
		res.push  = 1'b0;
		res.count = rd_hit_q ? ram_rdata : '0;
		unique case (state_q)
			ST_CLEAR: begin
				ram_we    = 1'b1;
				ram_waddr = clr_addr_q;
				ram_wdata = '0;
			end
			ST_IDLE: begin
				take = head.valid && ((head.cmd.kind != CMD_READ) || !out_full);
			end
			ST_SWEEP: begin
				issue = 1'b1;
			end
			ST_DRAIN: begin
				issue = 1'b0;
			end
			ST_READ: begin
				ram_re    = rd_hit_q;
				ram_raddr = rd_addr_q;
			end
			ST_RESULT: begin
				res.push = 1'b1;
			end
			default: begin
				issue = 1'b0;
			end
		endcase
	end

	assign stat.take = take;
	assign stat.init = init_q;

	// Control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_CLEAR;
			init_q     <= 1'b1;
			clr_addr_q <= '0;
			t_q        <= '0;
			v_s1       <= 1'b0;
			v_s2       <= 1'b0;
			v_s3       <= 1'b0;
			v_s4       <= 1'b0;
			v_s5       <= 1'b0;
			ok_s5      <= 1'b0;
			upd_s6     <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_CLEAR && clr_last) begin
				init_q <= 1'b0;
			end
			if (take && head.cmd.kind == CMD_CLEAR) begin
				clr_addr_q <= '0;
			end else if (state_q == ST_CLEAR) begin
				clr_addr_q <= clr_last ? '0 : clr_addr_q + 1'b1;
			end
			if (issue) begin
				t_q <= t_last ? '0 : t_q + 1'b1;
			end
			v_s1   <= issue;
			v_s2   <= v_s1;
			v_s3   <= v_s2;
			v_s4   <= v_s3;
			v_s5   <= v_s4;
			ok_s5  <= v_s4 && (bin_full >= 0) && (bin_full < rho_lim);
			upd_s6 <= ok_s5;
		end
	end

	// Latch the command operands on pop
	always_ff @(posedge clk) begin
		if (take) begin
			x_q       <= head.cmd.pix_x;
			y_q       <= head.cmd.pix_y;
			rd_hit_q  <= head.cmd.rd_hit;
			rd_addr_q <= head.cmd.rd_addr;
		end
	end

	// Datapath: trig lookup, products, sum, rounding, bin offset
	assign xs      = $signed({1'b0, x_q});
	assign ys      = $signed({1'b0, y_q});
	assign mag     = sum_s3[SUM_W-1] ? SUM_W'(-sum_s3) : SUM_W'(sum_s3);
	assign rnd     = mag + SUM_W'(1 << (FRAC_W-1));
	assign mag_ext = $signed(BSUM_W'(rmag_s4));
	assign rho_off = BSUM_W'(RHO_BINS / 2);
	assign rho_lim = BSUM_W'(RHO_BINS);
	assign bin_full = neg_s4 ? (rho_off - mag_ext) : (rho_off + mag_ext);

	always_ff @(posedge clk) begin
		t_s1    <= t_q;
		cos_s1  <= $signed(COS_TABLE[t_q*ROM_W +: ROM_W]);
		sin_s1  <= $signed(SIN_TABLE[t_q*ROM_W +: ROM_W]);
		t_s2    <= t_s1;
		px_s2   <= PROD_W'(xs) * PROD_W'(cos_s1);
		py_s2   <= PROD_W'(ys) * PROD_W'(sin_s1);
		t_s3    <= t_s2;
		sum_s3  <= SUM_W'(px_s2) + SUM_W'(py_s2);
		t_s4    <= t_s3;
		neg_s4  <= sum_s3[SUM_W-1];
		rmag_s4 <= rnd[SUM_W-1:FRAC_W];
		t_s5    <= t_s4;
		bin_s5  <= bin_full[BIN_W-1:0];
		addr_s6 <= sweep_addr;
	end

endmodule

@@ hw/rtl/hough_line_accumulator.sv @@
// Hough line accumulator. Every accepted pixel request with a nonzero value
// inside the image votes once per angle bin: rho = x*cos + y*sin with Q1.16
// tables, rounded half away from zero, and bin (angle, rho + RHO_BINS/2) is
// incremented modulo 2^COUNT_WIDTH; votes outside the store are dropped. A
// voting pixel is swept with one read-modify-write per angle through the store's
// one write port; the update pipeline then drains before the next request is
// taken. A read request returns one result; a clear request zeroes the store
// one word a cycle, all ANGLE_BINS * RHO_BINS = 368640 words. After reset the
// same clearing pass runs and full stays high throughout it. Requests that
// cause nothing (silent pixels, unused operation code) are accepted and
// dropped, and a four-deep queue lets requests arrive while a sweep runs or a
// result waits to be popped.
// Depends on hla_pkg, hla_front, hla_back, hla_ram.
module hough_line_accumulator (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            push,
	output logic                            full,
	input  logic [hla_pkg::OP_W-1:0]        operation,
	input  logic [hla_pkg::PIX_W-1:0]       pixel_x,
	input  logic [hla_pkg::PIX_W-1:0]       pixel_y,
	input  logic [hla_pkg::VAL_W-1:0]       pixel_value,
	input  logic [hla_pkg::ANG_FLD_W-1:0]   angle_bin,
	input  logic [hla_pkg::RHO_FLD_W-1:0]   rho_bin,
	output logic                            empty,
	input  logic                            pop,
	output logic [hla_pkg::COUNT_WIDTH-1:0] vote_count
);
	import hla_pkg::*;

	head_t                  head;
	back_stat_t             stat;
	res_t                   res;
	logic                   ram_we;
	logic [ADDR_W-1:0]      ram_waddr;
	logic [COUNT_WIDTH-1:0] ram_wdata;
	logic                   ram_re;
	logic [ADDR_W-1:0]      ram_raddr;
	logic [COUNT_WIDTH-1:0] ram_rdata;
	logic                   out_valid_q;
	logic [COUNT_WIDTH-1:0] vote_count_q;

	hla_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.push        (push),
		.full        (full),
		.operation   (operation),
		.pixel_x     (pixel_x),
		.pixel_y     (pixel_y),
		.pixel_value (pixel_value),
		.angle_bin   (angle_bin),
		.rho_bin     (rho_bin),
		.head        (head),
		.stat        (stat)
	);

	hla_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head      (head),
		.stat      (stat),
		.out_full  (out_valid_q),
		.res       (res),
		.ram_we    (ram_we),
		.ram_waddr (ram_waddr),
		.ram_wdata (ram_wdata),
		.ram_re    (ram_re),
		.ram_raddr (ram_raddr),
		.ram_rdata (ram_rdata)
	);

	hla_ram #(
		.WIDTH (COUNT_WIDTH),
		.DEPTH (STORE_DEPTH)
	) u_vote_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// Hold the result until it is popped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res.push) begin
			out_valid_q <= 1'b1;
		end else if (pop) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res.push) begin
			vote_count_q <= res.count;
		end
	end

	assign empty      = !out_valid_q;
	assign vote_count = vote_count_q;

	// A result is only produced into a free output slot
	assert property (@(posedge clk) disable iff (!arst_n) res.push |-> !out_valid_q)
		else $error("result produced while output slot occupied");

	// No request is taken while the store is being initialized
	assert property (@(posedge clk) disable iff (!arst_n) stat.init |-> full)
		else $error("request port open during initial clear");

	// Sweep read and write never touch the same word in one cycle
	assert property (@(posedge clk) disable iff (!arst_n)
		(ram_we && ram_re) |-> (ram_waddr != ram_raddr))
		else $error("read-modify-write collision in vote store");

	// The queue is only popped when it holds a command
	assert property (@(posedge clk) disable iff (!arst_n) stat.take |-> head.valid)
		else $error("command popped from empty queue");

endmodule

@@ verif/tb_hough_line_accumulator.sv @@
// Self-checking testbench for the Hough line accumulator: queued pixel, clear and
// read requests against an in-bench vote predictor, with random idling on both sides.
// Depends on hla_pkg and hough_line_accumulator.
`timescale 1ns / 1ps

module tb_hough_line_accumulator;
	import hla_pkg::*;

	localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
	localparam longint unsigned PI_Q30    = 64'd3373259426;
	localparam int SERIES_LEN = 14;
	localparam int RANDOM_REQS = 800;
	localparam int TAIL_CYCLES = 1000;
	localparam longint CYCLE_LIMIT = 64'd4000000;

	typedef struct {
		logic [OP_W-1:0]      op;
		logic [PIX_W-1:0]     px;
		logic [PIX_W-1:0]     py;
		logic [VAL_W-1:0]     pv;
		logic [ANG_FLD_W-1:0] ab;
		logic [RHO_FLD_W-1:0] rb;
		bit                   drain;
	} req_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic push = 1'b0;
	logic pop = 1'b0;
	logic [OP_W-1:0] operation = '0;
	logic [PIX_W-1:0] pixel_x = '0;
	logic [PIX_W-1:0] pixel_y = '0;
	logic [VAL_W-1:0] pixel_value = '0;
	logic [ANG_FLD_W-1:0] angle_bin = '0;
	logic [RHO_FLD_W-1:0] rho_bin = '0;
	logic full;
	logic empty;
	logic [COUNT_WIDTH-1:0] vote_count;

	// Predictor state: trig tables, vote counts and counts owed by the block
	longint cos_q16 [ANGLE_BINS];
	longint sin_q16 [ANGLE_BINS];
	bit [COUNT_WIDTH-1:0] vote_tally [STORE_DEPTH];
	logic [COUNT_WIDTH-1:0] due_counts [$];

	req_t pending [$];
	req_t cur_req;
	int sent_count = 0;
	int total_reqs = 1;
	int error_count = 0;
	longint cycle_count = 0;

	// Line generator state and pixels that recently voted
	int line_x, line_y, line_dx, line_dy, line_left = 0;
	int pool_x [$];
	int pool_y [$];

	hough_line_accumulator dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.push        (push),
		.full        (full),
		.operation   (operation),
		.pixel_x     (pixel_x),
		.pixel_y     (pixel_y),
		.pixel_value (pixel_value),
		.angle_bin   (angle_bin),
		.rho_bin     (rho_bin),
		.empty       (empty),
		.pop         (pop),
		.vote_count  (vote_count)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
	end

	// Round a Q30 value to Q16, ties away from zero
	function automatic longint q30_round(input longint v);
		if (v >= 0) begin
			return (v + 64'sd8192) >>> 14;
		end
		return -((-v + 64'sd8192) >>> 14);
	endfunction

	// Rho bin that pixel (x, y) votes for at angle bin t
	function automatic int vote_bin(input int x, input int y, input int t);
		longint p;
		longint rho;
		p = longint'(x) * cos_q16[t] + longint'(y) * sin_q16[t];
		if (p >= 0) begin
			rho = (p + 64'sd32768) >>> 16;
		end else begin
			rho = -((-p + 64'sd32768) >>> 16);
		end
		return int'(rho) + RHO_BINS / 2;
	endfunction

	// Update the predicted store for one accepted request
	function automatic void tally_request(input req_t r);
		int b;
		case (r.op)
			OP_ACCUM: begin
				if (r.pv != 0 && r.px >= 1 && r.px <= IMAGE_DIM &&
				    r.py >= 1 && r.py <= IMAGE_DIM) begin
					for (int t = 0; t < ANGLE_BINS; t++) begin
						b = vote_bin(int'(r.px), int'(r.py), t);
						if (b >= 0 && b < RHO_BINS) begin
							vote_tally[t * RHO_BINS + b] = vote_tally[t * RHO_BINS + b] + 1'b1;
						end
					end
				end
			end
			OP_CLEAR: begin
				foreach (vote_tally[i]) vote_tally[i] = '0;
			end
			OP_READ: begin
				if (r.ab < ANGLE_BINS && r.rb < RHO_BINS) begin
					due_counts.push_back(vote_tally[int'(r.ab) * RHO_BINS + int'(r.rb)]);
				end else begin
					due_counts.push_back('0);
				end
			end
			default: ;
		endcase
	endfunction

	function automatic int stage_now();
		return (sent_count * 3) / total_reqs;
	endfunction

	task automatic add_req(input logic [OP_W-1:0] op, input int px, input int py,
	                       input int pv, input int ab, input int rb, input bit drain = 1'b0);
		req_t r;
		r.op = op;
		r.px = PIX_W'(px);
		r.py = PIX_W'(py);
		r.pv = VAL_W'(pv);
		r.ab = ANG_FLD_W'(ab);
		r.rb = RHO_FLD_W'(rb);
		r.drain = drain;
		pending.push_back(r);
	endtask

	// Next pixel along the current line; start a new line when it runs out or leaves
	task automatic next_line_pixel(output int x, output int y);
		if (line_left == 0 || line_x < 1 || line_x > IMAGE_DIM ||
		    line_y < 1 || line_y > IMAGE_DIM) begin
			line_x = $urandom_range(1, IMAGE_DIM);
			line_y = $urandom_range(1, IMAGE_DIM);
			line_dx = $urandom_range(0, 6) - 3;
			line_dy = $urandom_range(0, 6) - 3;
			line_left = $urandom_range(4, 12);
		end
		x = line_x;
		y = line_y;
		line_x += line_dx;
		line_y += line_dy;
		line_left--;
	endtask

	// Present requests from the pending queue; hold a request until it is taken
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			push <= 1'b0;
		end else begin
			if (push && !full) begin
				tally_request(cur_req);
			end
			if (!push || !full) begin
				if (pending.size() != 0 && !(pending[0].drain && due_counts.size() != 0) &&
				    $urandom_range(0, 99) >= ((stage_now() == 0) ? 38 :
				                              (stage_now() == 1) ? 63 : 0)) begin
					cur_req = pending.pop_front();
					sent_count++;
					operation <= cur_req.op;
					pixel_x <= cur_req.px;
					pixel_y <= cur_req.py;
					pixel_value <= cur_req.pv;
					angle_bin <= cur_req.ab;
					rho_bin <= cur_req.rb;
					push <= 1'b1;
				end else begin
					push <= 1'b0;
				end
			end
		end
	end

	// Pop results at random and compare each with the oldest owed count
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pop <= 1'b0;
		end else begin
			logic [COUNT_WIDTH-1:0] want;
			if (pop && !empty) begin
				if (due_counts.size() == 0) begin
					$display("%0t: unexpected result, expected none, actual %0d",
					         $time, vote_count);
					error_count++;
				end else begin
					want = due_counts.pop_front();
					if (vote_count !== want) begin
						$display("%0t: vote_count mismatch, expected %0d, actual %0d",
						         $time, want, vote_count);
						error_count++;
					end
				end
			end
			pop <= ($urandom_range(0, 99) >= ((stage_now() == 0) ? 63 :
			                                  (stage_now() == 1) ? 38 : 0));
		end
	end

	// Abort a hung run
	initial begin
		wait (cycle_count >= CYCLE_LIMIT);
		$display("RESULT: ERROR");
		$finish;
	end

	initial begin
		bit flip;
		longint unsigned u, ang, sq, sterm, cterm, sdiv, cdiv;
		longint ssum, csum;
		int x, y, t, r, k;

		// Build Q1.16 tables by a Q30 Taylor series folded about pi/2
		for (t = 0; t < ANGLE_BINS; t++) begin
			flip = (2 * t) > ANGLE_BINS;
			u = flip ? 64'(ANGLE_BINS - t) : 64'(t);
			ang = (PI_Q30 * u + 64'(ANGLE_BINS / 2)) / 64'(ANGLE_BINS);
			sq = (ang * ang) >> 30;
			sterm = ang;
			cterm = 64'd1 << 30;
			ssum = longint'(ang);
			csum = longint'(64'd1 << 30);
			for (k = 1; k <= SERIES_LEN; k++) begin
				sdiv = 64'((2 * k) * (2 * k + 1));
				cdiv = 64'((2 * k - 1) * (2 * k));
				sterm = ((sterm * sq) >> 30) / sdiv;
				cterm = ((cterm * sq) >> 30) / cdiv;
				if (k % 2 == 1) begin
					ssum = ssum - longint'(sterm);
					csum = csum - longint'(cterm);
				end else begin
					ssum = ssum + longint'(sterm);
					csum = csum + longint'(cterm);
				end
			end
			sin_q16[t] = q30_round(ssum);
			cos_q16[t] = flip ? -q30_round(csum) : q30_round(csum);
		end

		// Directed: field extremes, ignored pixels, unused code, reads out of range, clear
		add_req(OP_READ, 0, 0, 0, 0, 0);
		add_req(OP_ACCUM, 1, 1, 255, 0, 0);
		add_req(OP_READ, 0, 0, 0, 0, vote_bin(1, 1, 0));
		add_req(OP_ACCUM, IMAGE_DIM, IMAGE_DIM, 1, 255, 2047);
		add_req(OP_ACCUM, IMAGE_DIM, 1, 128, 0, 0);
		add_req(OP_ACCUM, 1, IMAGE_DIM, 128, 0, 0);
		add_req(OP_READ, 0, 0, 0, ANGLE_BINS - 1, vote_bin(IMAGE_DIM, IMAGE_DIM, ANGLE_BINS - 1));
		add_req(OP_READ, 0, 0, 0, 90, vote_bin(IMAGE_DIM, 1, 90));
		add_req(OP_ACCUM, 100, 100, 0, 0, 0);
		add_req(OP_READ, 0, 0, 0, 45, vote_bin(100, 100, 45));
		add_req(OP_ACCUM, 0, 5, 1, 0, 0);
		add_req(OP_ACCUM, 5, 0, 1, 0, 0);
		add_req(OP_ACCUM, IMAGE_DIM + 1, 5, 1, 0, 0);
		add_req(OP_ACCUM, 1023, 1023, 255, 0, 0);
		add_req(OP_READ, 0, 0, 0, 10, vote_bin(5, 5, 10));
		add_req(OP_UNUSED, 1023, 1023, 255, 255, 2047);
		add_req(OP_READ, 0, 0, 0, ANGLE_BINS, 1024);
		add_req(OP_READ, 1023, 1023, 255, 255, 2047);
		add_req(OP_READ, 0, 0, 0, 0, 2047);
		add_req(OP_CLEAR, 0, 0, 0, 0, 0);
		add_req(OP_READ, 0, 0, 0, 0, vote_bin(1, 1, 0));
		add_req(OP_ACCUM, 1, 1, 255, 0, 0);
		add_req(OP_READ, 0, 0, 0, 0, vote_bin(1, 1, 0));

		// Random: mostly pixels along short lines and reads aimed at their bins
		for (int n = 0; n < RANDOM_REQS; n++) begin
			r = $urandom_range(0, 99);
			if (r < 40) begin
				next_line_pixel(x, y);
				pool_x.push_back(x);
				pool_y.push_back(y);
				if (pool_x.size() > 16) begin
					void'(pool_x.pop_front());
					void'(pool_y.pop_front());
				end
				add_req(OP_ACCUM, x, y, $urandom_range(1, 255), $urandom_range(0, 255),
				        $urandom_range(0, 2047), n == 130 || n == 400);
			end else if (r < 45) begin
				add_req(OP_ACCUM, $urandom_range(0, 1023), $urandom_range(0, 1023),
				        ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(0, 255),
				        $urandom_range(0, 255), $urandom_range(0, 2047), n == 130 || n == 400);
			end else if (r < 90 && pool_x.size() != 0) begin
				k = $urandom_range(0, pool_x.size() - 1);
				t = $urandom_range(0, ANGLE_BINS - 1);
				add_req(OP_READ, $urandom_range(0, 1023), $urandom_range(0, 1023),
				        $urandom_range(0, 255), t,
				        vote_bin(pool_x[k], pool_y[k], t) + $urandom_range(0, 2) - 1,
				        n == 130 || n == 400);
			end else if (r < 95 || r < 90) begin
				add_req(OP_READ, $urandom_range(0, 1023), $urandom_range(0, 1023),
				        $urandom_range(0, 255), $urandom_range(0, 255),
				        $urandom_range(0, 2047), n == 130 || n == 400);
			end else begin
				add_req(OP_UNUSED, $urandom_range(0, 1023), $urandom_range(0, 1023),
				        $urandom_range(0, 255), $urandom_range(0, 255),
				        $urandom_range(0, 2047), n == 130 || n == 400);
			end
		end
		total_reqs = pending.size();

		// Release reset
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		// Drain: every request taken, every count returned, then let sweeps finish
		while (pending.size() != 0 || push) @(negedge clk);
		while (due_counts.size() != 0) @(negedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);

		if (error_count == 0 && due_counts.size() == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

endmodule

@@ sim.f @@
hw/rtl/hla_pkg.sv
hw/rtl/hla_ram.sv
hw/rtl/hla_front.sv
hw/rtl/hla_back.sv
hw/rtl/hough_line_accumulator.sv
verif/tb_hough_line_accumulator.sv
